### design/rff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rff_pkg
// Shared constants, codes and types for the rectangle fill frame buffer.
// ----------------------------------------------------------------------------
package rff_pkg;

	localparam int FRAME_WIDTH  = 256;
	localparam int FRAME_HEIGHT = 256;

	localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W  = $clog2(FRAME_WIDTH + 1);
	localparam int ROW_W  = $clog2(FRAME_HEIGHT + 1);
	localparam int DIM_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
	// edge sums: 8-bit corner plus 9-bit size, and room for the frame size
	localparam int SUM_W  = (DIM_W > 10) ? DIM_W : 10;

	localparam int EXT_W = 9;
	localparam logic [EXT_W-1:0] EXTENT_MAX = 9'd511;

	localparam logic [23:0] WHITE = 24'hFFFFFF;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] KIND_PAINT = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PAINT,
		ST_READ,
		ST_CLEAR,
		ST_FINISH
	} back_state_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr0;
		logic [COL_W-1:0]  ncol;
		logic [ROW_W-1:0]  nrow;
		logic [23:0]       colour;
		logic              read_hit;
		logic              in_extent;
		logic              clipped;
		logic [EXT_W-1:0]  ext_w;
		logic [EXT_W-1:0]  ext_h;
	} cmd_t;

endpackage
`default_nettype wire

### design/rff_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rff_front
// Accepts items, clips paint rectangles, keeps the image extent and builds
// one command per item for the back end.
// ----------------------------------------------------------------------------
module rff_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        kind,
	input  wire logic [7:0]        pos_x,
	input  wire logic [7:0]        pos_y,
	input  wire logic [8:0]        rect_width,
	input  wire logic [8:0]        rect_height,
	input  wire logic [7:0]        red,
	input  wire logic [7:0]        green,
	input  wire logic [7:0]        blue,
	input  wire logic              init_busy,
	input  wire logic              q_full,
	output logic                   q_push,
	output rff_pkg::cmd_t          q_data
);
	import rff_pkg::*;

	logic [EXT_W-1:0] ext_w_q, ext_h_q;
	logic [EXT_W-1:0] ext_w_nx, ext_h_nx;
	logic [SUM_W-1:0] x0, y0, right, bottom, xe, ye;
	logic [EXT_W-1:0] ew, eh;
	logic             clip, in_frame;
	logic [31:0]      lin;

	assign in_ready = !q_full && !init_busy;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		x0     = SUM_W'(pos_x);
		y0     = SUM_W'(pos_y);
		right  = x0 + SUM_W'(rect_width);
		bottom = y0 + SUM_W'(rect_height);
		xe     = (right > SUM_W'(FRAME_WIDTH)) ? SUM_W'(FRAME_WIDTH) : right;
		ye     = (bottom > SUM_W'(FRAME_HEIGHT)) ? SUM_W'(FRAME_HEIGHT) : bottom;
		clip   = (right > SUM_W'(FRAME_WIDTH)) || (bottom > SUM_W'(FRAME_HEIGHT));
		ew     = (xe > SUM_W'(EXTENT_MAX)) ? EXTENT_MAX : xe[EXT_W-1:0];
		eh     = (ye > SUM_W'(EXTENT_MAX)) ? EXTENT_MAX : ye[EXT_W-1:0];
		in_frame = (x0 < SUM_W'(FRAME_WIDTH)) && (y0 < SUM_W'(FRAME_HEIGHT));
		lin    = 32'(pos_y) * 32'(FRAME_WIDTH) + 32'(pos_x);

		ext_w_nx = ext_w_q;
		ext_h_nx = ext_h_q;
		case (kind)
			KIND_PAINT: begin
				if (ew > ext_w_q) ext_w_nx = ew;
				if (eh > ext_h_q) ext_h_nx = eh;
			end
			KIND_CLEAR: begin
				ext_w_nx = '0;
				ext_h_nx = '0;
			end
			default: begin
			end
		endcase

		q_data          = '0;
		q_data.kind     = kind;
		q_data.addr0    = lin[ADDR_W-1:0];
		q_data.colour   = {red, green, blue};
		q_data.ext_w    = ext_w_nx;
		q_data.ext_h    = ext_h_nx;
		if (kind == KIND_PAINT) begin
			q_data.clipped = clip;
			q_data.ncol    = (xe > x0) ? COL_W'(xe - x0) : '0;
			q_data.nrow    = (ye > y0) ? ROW_W'(ye - y0) : '0;
		end
		if (kind == KIND_READ) begin
			q_data.read_hit  = in_frame;
			q_data.in_extent = (EXT_W'(pos_x) < ext_w_q) && (EXT_W'(pos_y) < ext_h_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_w_q <= '0;
			ext_h_q <= '0;
		end else if (q_push) begin
			ext_w_q <= ext_w_nx;
			ext_h_q <= ext_h_nx;
		end
	end

endmodule
`default_nettype wire

### design/rff_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rff_queue
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rff_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rff_pkg::cmd_t     push_data,
	output logic                   full,
	input  wire logic              pop,
	output rff_pkg::cmd_t          head,
	output logic                   empty
);
	import rff_pkg::*;

	cmd_t               entries_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push, do_pop;

	assign full    = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### design/rff_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rff_back
// Owns the frame store: sweeps it white, fills rectangles one pixel a cycle,
// reads pixels and holds the result register.
// ----------------------------------------------------------------------------
module rff_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire rff_pkg::cmd_t     q_head,
	output logic                   q_pop,
	output logic                   init_busy,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             pix_red,
	output logic [7:0]             pix_green,
	output logic [7:0]             pix_blue,
	output logic [8:0]             image_width,
	output logic [8:0]             image_height,
	output logic                   inside_res,
	output logic                   clipped
);
	import rff_pkg::*;

	logic [23:0]       mem [DEPTH];
	logic [23:0]       rd_q;

	back_state_t       state_q, state_nx;
	cmd_t              cmd_q;
	logic [ADDR_W-1:0] addr_q, row_base_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic              mem_we, rd_en, load_out, slot_free, sweep_last;
	logic [ADDR_W-1:0] mem_waddr;
	logic [23:0]       mem_wdata;
	logic              out_valid_q;

	assign slot_free  = !out_valid_q || out_ready;
	assign sweep_last = (addr_q == ADDR_W'(DEPTH - 1));
	assign init_busy  = (state_q == ST_INIT);
	assign rd_en      = (state_q == ST_READ) && cmd_q.read_hit;
	assign out_valid  = out_valid_q;

	always_comb begin
		state_nx  = state_q;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = WHITE;
		q_pop     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				if (sweep_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					case (q_head.kind)
						KIND_PAINT: begin
							if (q_head.ncol != '0 && q_head.nrow != '0)
								state_nx = ST_PAINT;
							else
								state_nx = ST_FINISH;
						end
						KIND_READ:  state_nx = ST_READ;
						KIND_CLEAR: state_nx = ST_CLEAR;
						default:    state_nx = ST_FINISH;
					endcase
				end
			end
			ST_PAINT: begin
				mem_we    = 1'b1;
				mem_wdata = cmd_q.colour;
				if (col_q == COL_W'(1) && row_q == ROW_W'(1)) state_nx = ST_FINISH;
			end
			ST_READ: begin
				state_nx = ST_FINISH;
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_last) state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			addr_q     <= '0;
			row_base_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
				end
				ST_IDLE: begin
					if (q_pop) begin
						// clear sweeps from the first pixel, paint from the corner
						addr_q     <= (q_head.kind == KIND_CLEAR) ? '0 : q_head.addr0;
						row_base_q <= q_head.addr0;
						col_q      <= q_head.ncol;
						row_q      <= q_head.nrow;
					end
				end
				ST_PAINT: begin
					if (col_q == COL_W'(1)) begin
						// step down to the start of the next row
						row_base_q <= row_base_q + ADDR_W'(FRAME_WIDTH);
						addr_q     <= row_base_q + ADDR_W'(FRAME_WIDTH);
						col_q      <= cmd_q.ncol;
						row_q      <= row_q - 1'b1;
					end else begin
						addr_q <= addr_q + 1'b1;
						col_q  <= col_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_head;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= mem[cmd_q.addr0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			{pix_red, pix_green, pix_blue} <= cmd_q.read_hit ? rd_q : 24'd0;
			image_width  <= cmd_q.ext_w;
			image_height <= cmd_q.ext_h;
			inside_res   <= cmd_q.in_extent;
			clipped      <= cmd_q.clipped;
		end
	end

	a_paint_counts_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAINT |-> (col_q != '0 && row_q != '0))
		else $error("paint running with an empty row or column count");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("result appeared without a finished command");

	a_init_leads_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT |=> (state_q == ST_INIT || state_q == ST_IDLE))
		else $error("reset sweep left for a state other than idle");

endmodule
`default_nettype wire

### design/rectangle_fill_framebuffer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// from transfer in to out_valid: the item is queued, popped in idle, run in its
// read, paint or clear state, then loaded out in finish once the output is free
// throughput: one item at a time in the back end, which fills one pixel a cycle
// through its single memory write port; the queue takes up to 4 items ahead
// reset: extent cleared, then a sweep whitens the frame store one pixel a cycle
// while in_ready is held low
// ----------------------------------------------------------------------------
// rectangle_fill_framebuffer_top
// Rectangle fill frame buffer: paint, read and clear over a 24-bit RGB store.
// ----------------------------------------------------------------------------
module rectangle_fill_framebuffer_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] pos_x,
	input  wire logic [7:0] pos_y,
	input  wire logic [8:0] rect_width,
	input  wire logic [8:0] rect_height,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      pix_red,
	output logic [7:0]      pix_green,
	output logic [7:0]      pix_blue,
	output logic [8:0]      image_width,
	output logic [8:0]      image_height,
	output logic            inside_res,
	output logic            clipped
);
	import rff_pkg::*;

	cmd_t q_data, q_head;
	logic q_push, q_full, q_pop, q_empty, init_busy;

	rff_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.init_busy   (init_busy),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_data)
	);

	rff_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	rff_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.init_busy    (init_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pix_red      (pix_red),
		.pix_green    (pix_green),
		.pix_blue     (pix_blue),
		.image_width  (image_width),
		.image_height (image_height),
		.inside_res   (inside_res),
		.clipped      (clipped)
	);

endmodule
`default_nettype wire
